>>> design/rtype_integer_execute_unit_top_defines.svh
// Assertion macros shared by the execute unit RTL.
`ifndef RTYPE_INTEGER_EXECUTE_UNIT_TOP_DEFINES_SVH
`define RTYPE_INTEGER_EXECUTE_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RIEU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define RIEU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/rieu_pkg.sv
// Shared types, codes and constants of the R-type execute unit.
`timescale 1ns / 1ps
package rieu_pkg;

   localparam int unsigned IdxW = 23;

   localparam logic [31:0] TEXT_BASE  = 32'h1000_0000;
   localparam logic [31:0] TEXT_LIMIT = 32'h1100_0000;

   localparam logic [1:0] REQ_EXEC  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_SETPC = 2'd2;
   localparam logic [1:0] REQ_RSVD  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_RSV  = 2'd2;
   localparam logic [1:0] ST_JUMP = 2'd3;

   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SRL   = 6'h02;
   localparam logic [5:0] FN_SRA   = 6'h03;
   localparam logic [5:0] FN_SLLV  = 6'h04;
   localparam logic [5:0] FN_SRLV  = 6'h06;
   localparam logic [5:0] FN_SRAV  = 6'h07;
   localparam logic [5:0] FN_JR    = 6'h08;
   localparam logic [5:0] FN_JALR  = 6'h09;
   localparam logic [5:0] FN_MFHI  = 6'h10;
   localparam logic [5:0] FN_MTHI  = 6'h11;
   localparam logic [5:0] FN_MFLO  = 6'h12;
   localparam logic [5:0] FN_MTLO  = 6'h13;
   localparam logic [5:0] FN_MULT  = 6'h18;
   localparam logic [5:0] FN_MULTU = 6'h19;
   localparam logic [5:0] FN_DIV   = 6'h1A;
   localparam logic [5:0] FN_DIVU  = 6'h1B;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_ADDU  = 6'h21;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_SUBU  = 6'h23;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_XOR   = 6'h26;
   localparam logic [5:0] FN_SLT   = 6'h2A;
   localparam logic [5:0] FN_SLTU  = 6'h2B;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic read;
      logic exec;
      logic mul_done;
      logic div_step;
      logic div_done;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mul_op;
      logic div_op;
      logic div_last;
   } stat_type;

endpackage

>>> design/rieu_ifs.sv
// Request and response channel interfaces of the execute unit.
`timescale 1ns / 1ps
interface rieu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] instr_word;
   logic [4:0]  reg_index;
   logic [31:0] load_value;

   modport source (output valid, req_type, instr_word, reg_index, load_value, input ready);
   modport sink (input valid, req_type, instr_word, reg_index, load_value, output ready);
endinterface

interface rieu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [31:0]                 next_pc;
   logic [rieu_pkg::IdxW-1:0]   instr_index;
   logic                        wrote_reg;
   logic [4:0]                  dest_reg;
   logic [31:0]                 dest_value;

   modport source (output valid, status, next_pc, instr_index, wrote_reg, dest_reg,
                   dest_value, input ready);
   modport sink (input valid, status, next_pc, instr_index, wrote_reg, dest_reg,
                 dest_value, output ready);
endinterface

>>> design/rieu_ctrl.sv
// Sequencing state machine of the execute unit.
`timescale 1ns / 1ps
module rieu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  rieu_pkg::stat_type stat,
   output rieu_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_READ = 7'b0000010,
      S_EXEC = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_DFIX = 7'b0100000,
      S_WB   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.mul_op)      state_in = S_MUL;
            else if (stat.div_op) state_in = S_DIV;
            else                  state_in = S_WB;
         end
         S_MUL: begin
            cmd.mul_done = 1'b1;
            state_in = S_WB;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_DFIX;
         end
         S_DFIX: begin
            cmd.div_done = 1'b1;
            state_in = S_WB;
         end
         S_WB: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/rieu_dp.sv
// Datapath: register file, ALU, multiplier, divider and architectural state.
`timescale 1ns / 1ps
module rieu_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   req_type,
   input  logic [31:0]                  instr_word,
   input  logic [4:0]                   reg_index,
   input  logic [31:0]                  load_value,
   input  rieu_pkg::cmd_type            cmd,
   output rieu_pkg::stat_type           stat,
   output logic [1:0]                   status,
   output logic [31:0]                  next_pc,
   output logic [rieu_pkg::IdxW-1:0]    instr_index,
   output logic                         wrote_reg,
   output logic [4:0]                   dest_reg,
   output logic [31:0]                  dest_value
);

   localparam int unsigned IW = rieu_pkg::IdxW;

   // Latched request.
   logic [1:0]  rtype_ff;
   logic [31:0] instr_ff, lv_ff;
   logic [4:0]  ridx_ff;

   // Register file with per-entry valid bits (unwritten entries read as zero).
   logic [31:0] regs_mem [32];
   logic [31:0] vld_ff;
   logic [31:0] rs_data_ff, rt_data_ff;
   logic        rs_vld_ff, rt_vld_ff;

   // Architectural state.
   logic [31:0]   hi_ff, lo_ff, pc_ff;
   logic [IW-1:0] idx_ff;

   // Pending result.
   logic [1:0]    res_st_ff;
   logic          res_wreg_ff;
   logic [4:0]    res_rd_ff;
   logic [31:0]   res_val_ff, res_hi_ff, res_lo_ff, res_pc_ff;
   logic [IW-1:0] res_idx_ff;

   // Multiplier and divider.
   logic [63:0] prod_ff;
   logic [31:0] rem_ff, quo_ff, mb_ff;
   logic [4:0]  cnt_ff;
   logic        negq_ff, negr_ff;

   // Response payload registers.
   logic [1:0]    o_st_ff;
   logic [31:0]   o_pc_ff, o_val_ff;
   logic [IW-1:0] o_idx_ff;
   logic          o_wr_ff;
   logic [4:0]    o_rd_ff;

   logic [4:0]  rs, rt, rd, sh;
   logic [5:0]  fn;
   logic [31:0] a, b;
   logic [1:0]  x_st;
   logic        x_wreg, x_mul, x_div;
   logic [4:0]  x_rd;
   logic [31:0] x_val, x_pc, x_sum, x_dif, x_jdif;
   logic [IW-1:0] x_idx;
   logic        jump_ok;
   logic        dsgn;
   logic [32:0] op_a, op_b;
   logic [65:0] prod_full;
   logic [32:0] trial;
   logic        ok, wr_en;

   assign rs = instr_ff[25:21];
   assign rt = instr_ff[20:16];
   assign rd = instr_ff[15:11];
   assign sh = instr_ff[10:6];
   assign fn = instr_ff[5:0];
   assign a  = rs_vld_ff ? rs_data_ff : 32'd0;
   assign b  = rt_vld_ff ? rt_data_ff : 32'd0;

   assign x_sum  = a + b;
   assign x_dif  = a - b;
   assign x_jdif = a - rieu_pkg::TEXT_BASE;
   assign jump_ok = (a >= rieu_pkg::TEXT_BASE) && (a <= rieu_pkg::TEXT_LIMIT)
                    && (a[1:0] == 2'b00);

   always_comb begin
      x_st   = rieu_pkg::ST_OK;
      x_wreg = 1'b0;
      x_rd   = rd;
      x_val  = 32'd0;
      x_pc   = pc_ff + 32'd4;
      x_idx  = idx_ff + IW'(1);
      x_mul  = 1'b0;
      x_div  = 1'b0;
      case (rtype_ff)
         rieu_pkg::REQ_WRITE: begin
            x_wreg = 1'b1;
            x_rd   = ridx_ff;
            x_val  = lv_ff;
            x_pc   = pc_ff;
            x_idx  = idx_ff;
         end
         rieu_pkg::REQ_SETPC: begin
            x_pc  = lv_ff;
            x_idx = idx_ff;
         end
         rieu_pkg::REQ_EXEC: begin
            if (sh != 5'd0 && fn != rieu_pkg::FN_SLL && fn != rieu_pkg::FN_SRL
                && fn != rieu_pkg::FN_SRA) begin
               x_st = rieu_pkg::ST_RSV;
            end else begin
               case (fn)
                  rieu_pkg::FN_SLL:  begin x_val = b << sh; x_wreg = 1'b1; end
                  rieu_pkg::FN_SRL:  begin x_val = b >> sh; x_wreg = 1'b1; end
                  rieu_pkg::FN_SRA:  begin x_val = $signed(b) >>> sh; x_wreg = 1'b1; end
                  rieu_pkg::FN_SLLV: begin x_val = b << a[4:0]; x_wreg = 1'b1; end
                  rieu_pkg::FN_SRLV: begin x_val = b >> a[4:0]; x_wreg = 1'b1; end
                  rieu_pkg::FN_SRAV: begin
                     x_val = $signed(b) >>> a[4:0];
                     x_wreg = 1'b1;
                  end
                  rieu_pkg::FN_ADD: begin
                     x_val = x_sum;
                     if ((a[31] ^ x_sum[31]) && (b[31] ^ x_sum[31])) x_st = rieu_pkg::ST_OVF;
                     else x_wreg = 1'b1;
                  end
                  rieu_pkg::FN_SUB: begin
                     x_val = x_dif;
                     if ((a[31] ^ b[31]) && (a[31] ^ x_dif[31])) x_st = rieu_pkg::ST_OVF;
                     else x_wreg = 1'b1;
                  end
                  rieu_pkg::FN_ADDU: begin x_val = x_sum; x_wreg = 1'b1; end
                  rieu_pkg::FN_SUBU: begin x_val = x_dif; x_wreg = 1'b1; end
                  rieu_pkg::FN_AND:  begin x_val = a & b; x_wreg = 1'b1; end
                  rieu_pkg::FN_OR:   begin x_val = a | b; x_wreg = 1'b1; end
                  rieu_pkg::FN_XOR:  begin x_val = a ^ b; x_wreg = 1'b1; end
                  rieu_pkg::FN_SLT: begin
                     x_val = {31'd0, $signed(a) < $signed(b)};
                     x_wreg = 1'b1;
                  end
                  rieu_pkg::FN_SLTU: begin x_val = {31'd0, a < b}; x_wreg = 1'b1; end
                  rieu_pkg::FN_MULT, rieu_pkg::FN_MULTU: x_mul = 1'b1;
                  rieu_pkg::FN_DIV, rieu_pkg::FN_DIVU: x_div = (b != 32'd0);
                  rieu_pkg::FN_MFHI: begin x_val = hi_ff; x_wreg = 1'b1; end
                  rieu_pkg::FN_MFLO: begin x_val = lo_ff; x_wreg = 1'b1; end
                  rieu_pkg::FN_MTHI, rieu_pkg::FN_MTLO: x_wreg = 1'b0;
                  rieu_pkg::FN_JR: begin
                     if (a == 32'd0) begin
                        x_pc  = 32'd0;
                        x_idx = idx_ff;
                     end else if (jump_ok) begin
                        x_pc  = a;
                        x_idx = x_jdif[IW+1:2];
                     end else begin
                        x_st = rieu_pkg::ST_JUMP;
                     end
                  end
                  rieu_pkg::FN_JALR: begin
                     if (rs == rd) begin
                        x_st = rieu_pkg::ST_RSV;
                     end else if (jump_ok) begin
                        x_val  = pc_ff + 32'd8;
                        x_wreg = 1'b1;
                        x_pc   = a;
                        x_idx  = x_jdif[IW+1:2];
                     end else begin
                        x_st = rieu_pkg::ST_JUMP;
                     end
                  end
                  default: x_st = rieu_pkg::ST_RSV;
               endcase
            end
         end
         default: x_st = rieu_pkg::ST_RSV;
      endcase
   end

   assign stat.mul_op   = x_mul;
   assign stat.div_op   = x_div;
   assign stat.div_last = (cnt_ff == 5'd31);

   // Multiplier operands: 33-bit signed so one product serves both forms.
   assign dsgn      = (fn == rieu_pkg::FN_MULT) || (fn == rieu_pkg::FN_DIV);
   assign op_a      = {dsgn & a[31], a};
   assign op_b      = {dsgn & b[31], b};
   assign prod_full = $signed(op_a) * $signed(op_b);

   // One restoring division step.
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, mb_ff};

   assign ok    = (res_st_ff == rieu_pkg::ST_OK);
   assign wr_en = cmd.commit && ok && res_wreg_ff && (res_rd_ff != 5'd0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rtype_ff <= req_type;
         instr_ff <= instr_word;
         ridx_ff  <= reg_index;
         lv_ff    <= load_value;
      end
      if (cmd.read) begin
         rs_data_ff <= regs_mem[instr_ff[25:21]];
         rt_data_ff <= regs_mem[instr_ff[20:16]];
         rs_vld_ff  <= vld_ff[instr_ff[25:21]];
         rt_vld_ff  <= vld_ff[instr_ff[20:16]];
      end
      if (wr_en) regs_mem[res_rd_ff] <= res_val_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_st_ff   <= x_st;
         res_wreg_ff <= x_wreg;
         res_rd_ff   <= x_rd;
         res_val_ff  <= x_val;
         res_pc_ff   <= x_pc;
         res_idx_ff  <= x_idx;
         res_hi_ff   <= (fn == rieu_pkg::FN_MTHI && rtype_ff == rieu_pkg::REQ_EXEC) ? a : hi_ff;
         res_lo_ff   <= (fn == rieu_pkg::FN_MTLO && rtype_ff == rieu_pkg::REQ_EXEC) ? a : lo_ff;
         prod_ff     <= prod_full[63:0];
         rem_ff      <= 32'd0;
         quo_ff      <= (dsgn && a[31]) ? (32'd0 - a) : a;
         mb_ff       <= (dsgn && b[31]) ? (32'd0 - b) : b;
         negq_ff     <= dsgn && (a[31] ^ b[31]);
         negr_ff     <= dsgn && a[31];
         cnt_ff      <= 5'd0;
      end
      if (cmd.mul_done) begin
         res_hi_ff <= prod_ff[63:32];
         res_lo_ff <= prod_ff[31:0];
      end
      if (cmd.div_step) begin
         rem_ff <= trial[32] ? {rem_ff[30:0], quo_ff[31]} : trial[31:0];
         quo_ff <= {quo_ff[30:0], ~trial[32]};
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (cmd.div_done) begin
         res_lo_ff <= negq_ff ? (32'd0 - quo_ff) : quo_ff;
         res_hi_ff <= negr_ff ? (32'd0 - rem_ff) : rem_ff;
      end
      if (cmd.commit) begin
         o_st_ff  <= res_st_ff;
         o_pc_ff  <= ok ? res_pc_ff : pc_ff;
         o_idx_ff <= ok ? res_idx_ff : idx_ff;
         o_wr_ff  <= wr_en;
         o_rd_ff  <= wr_en ? res_rd_ff : 5'd0;
         o_val_ff <= wr_en ? res_val_ff : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hi_ff  <= 32'd0;
         lo_ff  <= 32'd0;
         pc_ff  <= rieu_pkg::TEXT_BASE;
         idx_ff <= '0;
      end else if (cmd.commit && ok) begin
         if (wr_en) vld_ff[res_rd_ff] <= 1'b1;
         hi_ff  <= res_hi_ff;
         lo_ff  <= res_lo_ff;
         pc_ff  <= res_pc_ff;
         idx_ff <= res_idx_ff;
      end
   end

   assign status      = o_st_ff;
   assign next_pc     = o_pc_ff;
   assign instr_index = o_idx_ff;
   assign wrote_reg   = o_wr_ff;
   assign dest_reg    = o_rd_ff;
   assign dest_value  = o_val_ff;

endmodule

>>> design/rtype_integer_execute_unit_top.sv
// Top level of the R-type integer execute unit.
`timescale 1ns / 1ps
// Usage:
// Items arrive on req_chan (valid/ready). An item either executes one R-type
// instruction word, writes a general register, or sets the program counter.
// Every item yields exactly one result item on rsp_chan, carrying the status,
// the program counter and instruction index after the item, and the register
// write it made, if any.
// The unit works on one item at a time. An ordinary instruction or request
// passes through read, execute and writeback; a multiply adds a product step,
// and a divide with a nonzero divisor adds the 32-step restoring divider and a
// sign fix-up before writeback. The next item is taken once the unit is back
// in idle, in the cycle after the result is loaded.
// The result sits in an output register, so a stalled receiver does not stop
// the next item from being accepted and worked on; that item waits only at
// writeback until the output register is free.
// Reset clears the register file, HI and LO, sets the program counter to the
// start of the text segment and the index to zero.
`include "rtype_integer_execute_unit_top_defines.svh"
module rtype_integer_execute_unit_top (
   input logic        clock,
   input logic        reset,
   rieu_req_if.sink   req_chan,
   rieu_rsp_if.source rsp_chan
);

   rieu_pkg::cmd_type  cmd;
   rieu_pkg::stat_type stat;
   logic               req_fire, rsp_free, rsp_fault;

   // Controller: sequencing and the handshakes.
   rieu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: state, arithmetic and result payload.
   rieu_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_type    (req_chan.req_type),
      .instr_word  (req_chan.instr_word),
      .reg_index   (req_chan.reg_index),
      .load_value  (req_chan.load_value),
      .cmd         (cmd),
      .stat        (stat),
      .status      (rsp_chan.status),
      .next_pc     (rsp_chan.next_pc),
      .instr_index (rsp_chan.instr_index),
      .wrote_reg   (rsp_chan.wrote_reg),
      .dest_reg    (rsp_chan.dest_reg),
      .dest_value  (rsp_chan.dest_value)
   );

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_free  = !rsp_chan.valid || rsp_chan.ready;
   assign rsp_fault = rsp_chan.valid && (rsp_chan.status != rieu_pkg::ST_OK);

   // A just-accepted item keeps the unit busy in the following cycle.
   `RIEU_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_chan.ready, "ready after accept")
   // Writeback only loads the output register when it is free.
   `RIEU_ASSERT_SAME(a_commit_slot_free, cmd.commit, rsp_free, "result overwritten")
   // A faulting item never reports a register write.
   `RIEU_ASSERT_SAME(a_fault_no_write, rsp_fault, !rsp_chan.wrote_reg, "write on a fault")

endmodule
